// ----- rtl/fbc_pkg.sv -----
package fbc_pkg;

  // operation codes of an input item
  typedef enum logic [2:0] {
    OP_COMMAND = 3'd0,
    OP_READ    = 3'd1,
    OP_WRITE   = 3'd2,
    OP_PAYLOAD = 3'd3,
    OP_RECEIVE = 3'd4
  } op_t;

  localparam logic [7:0]  ESC_BYTE      = 8'h2F;
  localparam logic [7:0]  OP_READ_CODE  = 8'h3A;
  localparam logic [7:0]  OP_WRITE_CODE = 8'h3B;
  localparam logic [7:0]  PARAM_LEN     = 8'h01;
  localparam logic [15:0] CRC_POLY      = 16'h1021;
  localparam logic [15:0] CRC_TOP       = 16'h8000;

  localparam int JOB_BYTES = 6;

  // one unit of work handed from front to back
  typedef struct packed {
    logic                   kind;    // 0 frame bytes, 1 receive verdict
    logic                   ok;      // verdict value
    logic [2:0]             count;   // data bytes held, 1 to 6
    logic                   fresh;   // restart the running crc at the first byte
    logic                   append;  // send crc high and low after the data bytes
    logic [JOB_BYTES-1:0][7:0] bytes;
  } job_t;

  // crc-16 xmodem, one byte msb first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/fbc_front.sv -----
module fbc_front
  import fbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [2:0]  operation,
  input  logic [7:0]  command,
  input  logic [15:0] address,
  input  logic [8:0]  length,
  input  logic [7:0]  device,
  input  logic [7:0]  data_byte,
  input  logic        frame_end,
  input  logic        queue_full,
  output logic        job_push,
  output job_t        job
);

  logic [8:0]  write_remaining, write_remaining_next;
  logic [15:0] rx_crc, rx_crc_next;
  logic [15:0] rx_last_two, rx_last_two_next;
  logic [1:0]  rx_seen, rx_seen_next;
  logic        accept;
  logic        produce;
  logic [7:0]  len8;

  assign item_stall = queue_full;
  assign accept     = item_valid && !queue_full;
  assign job_push   = accept && produce;
  assign len8       = length[7:0];

  always_comb begin
    write_remaining_next = write_remaining;
    rx_crc_next          = rx_crc;
    rx_last_two_next     = rx_last_two;
    rx_seen_next         = rx_seen;
    produce              = 1'b0;
    job                  = '0;
    unique case (operation)
      OP_COMMAND: begin
        write_remaining_next = 9'd0;
        produce    = 1'b1;
        job.count  = 3'd6;
        job.fresh  = 1'b1;
        job.append = 1'b1;
        job.bytes[0] = ESC_BYTE;
        job.bytes[1] = command;
        job.bytes[2] = 8'h00;
        job.bytes[3] = 8'h00;
        job.bytes[4] = PARAM_LEN;
        job.bytes[5] = device;
      end
      OP_READ: begin
        write_remaining_next = 9'd0;
        produce    = 1'b1;
        job.count  = 3'd6;
        job.fresh  = 1'b1;
        job.append = 1'b1;
        job.bytes[0] = ESC_BYTE;
        job.bytes[1] = OP_READ_CODE;
        job.bytes[2] = address[15:8];
        job.bytes[3] = address[7:0];
        job.bytes[4] = PARAM_LEN;
        job.bytes[5] = len8;
      end
      OP_WRITE: begin
        write_remaining_next = (len8 == 8'h00) ? 9'd256 : {1'b0, len8};
        produce    = 1'b1;
        job.count  = 3'd5;
        job.fresh  = 1'b1;
        job.bytes[0] = ESC_BYTE;
        job.bytes[1] = OP_WRITE_CODE;
        job.bytes[2] = address[15:8];
        job.bytes[3] = address[7:0];
        job.bytes[4] = len8;
      end
      OP_PAYLOAD: begin
        if (write_remaining != 9'd0) begin
          write_remaining_next = write_remaining - 9'd1;
          produce    = 1'b1;
          job.count  = 3'd1;
          job.append = (write_remaining == 9'd1);
          job.bytes[0] = data_byte;
        end
      end
      OP_RECEIVE: begin
        if (rx_seen == 2'd2) begin
          rx_crc_next = crc_feed(rx_crc, rx_last_two[15:8]);
        end
        rx_last_two_next = {rx_last_two[7:0], data_byte};
        if (rx_seen != 2'd2) begin
          rx_seen_next = rx_seen + 2'd1;
        end
        if (frame_end) begin
          produce   = 1'b1;
          job.kind  = 1'b1;
          job.count = 3'd1;
          job.ok    = (rx_seen_next == 2'd2) && (rx_crc_next == rx_last_two_next);
          rx_crc_next      = 16'h0000;
          rx_last_two_next = 16'h0000;
          rx_seen_next     = 2'd0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_remaining <= 9'd0;
      rx_crc          <= 16'h0000;
      rx_last_two     <= 16'h0000;
      rx_seen         <= 2'd0;
    end else if (accept) begin
      write_remaining <= write_remaining_next;
      rx_crc          <= rx_crc_next;
      rx_last_two     <= rx_last_two_next;
      rx_seen         <= rx_seen_next;
    end
  end

endmodule

// ----- rtl/fbc_queue.sv -----
module fbc_queue
  import fbc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head
);

  job_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ----- rtl/fbc_back.sv -----
module fbc_back
  import fbc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  job_t       head,
  output logic       pop,
  output logic       result_valid,
  input  logic       result_stall,
  output logic       kind,
  output logic [7:0] out_byte,
  output logic       crc_ok,
  output logic       last
);

  logic [2:0]  idx;
  logic [15:0] crc;
  logic        is_data;
  logic [7:0]  data_sel;
  logic [7:0]  crc_sel;
  logic        transfer;
  logic [15:0] crc_base;

  assign result_valid = head_valid;
  assign transfer     = head_valid && !result_stall;
  assign is_data      = (idx < head.count);
  assign pop          = transfer && last;

  always_comb begin
    if (idx < 3'(JOB_BYTES)) begin
      data_sel = head.bytes[idx];
    end else begin
      data_sel = 8'h00;
    end
    crc_sel  = (idx == head.count) ? crc[15:8] : crc[7:0];
    crc_base = (head.fresh && idx == 3'd0) ? 16'h0000 : crc;
  end

  always_comb begin
    kind = head.kind;
    if (head.kind) begin
      out_byte = 8'h00;
      crc_ok   = head.ok;
      last     = 1'b1;
    end else begin
      out_byte = is_data ? data_sel : crc_sel;
      crc_ok   = 1'b0;
      if (head.append) begin
        last = (idx == 3'(head.count + 3'd1));
      end else begin
        last = (idx == 3'(head.count - 3'd1));
      end
    end
  end

  // running crc follows every data byte of a frame as it leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= 16'h0000;
    end else if (transfer && !head.kind && is_data) begin
      crc <= crc_feed(crc_base, data_sel);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 3'd0;
    end else if (transfer) begin
      if (last) begin
        idx <= 3'd0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

endmodule

// ----- rtl/four_way_frame_builder_checker.sv -----
// frame builder and checker for escape-prefixed interface frames with crc-16 xmodem
// (polynomial 0x1021, start 0, msb first, high crc byte first). the front stage takes one
// input transfer per cycle while the two-entry job queue has room, tracks the open write
// and checks received bytes on the spot; the back stage sends one result transfer per
// cycle while result_stall is low and works out the transmit crc byte by byte as the frame
// leaves. a command or read frame gives eight results and a write header five, and the
// input stalls while the queue holds the job being sent plus one more.
// a payload byte gives one result (the closing one three), a received byte gives none
// until the last byte of its frame, which gives the verdict; these flow at one item per
// cycle while the queue has room and result_stall is low.
module four_way_frame_builder_checker
  import fbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input item channel
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [2:0]  operation,
  input  logic [7:0]  command,
  input  logic [15:0] address,
  input  logic [8:0]  length,
  input  logic [7:0]  device,
  input  logic [7:0]  data_byte,
  input  logic        frame_end,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic        kind,
  output logic [7:0]  out_byte,
  output logic        crc_ok,
  output logic        last
);

  job_t push_job;
  job_t head;
  logic job_push;
  logic queue_full;
  logic head_valid;
  logic pop;

  // front: accepts transfers, classifies them and builds jobs
  fbc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .operation  (operation),
    .command    (command),
    .address    (address),
    .length     (length),
    .device     (device),
    .data_byte  (data_byte),
    .frame_end  (frame_end),
    .queue_full (queue_full),
    .job_push   (job_push),
    .job        (push_job)
  );

  // short queue lets each side stall on its own
  fbc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (job_push),
    .push_job   (push_job),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // back: expands a job into result transfers, appends the crc where due
  fbc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .out_byte     (out_byte),
    .crc_ok       (crc_ok),
    .last         (last)
  );

endmodule
